/* rtl/core/lnc_pkg.sv */
package lnc_pkg;

    localparam int unsigned LFSR_W      = 15;
    localparam int unsigned PERIOD_W    = 23;
    localparam int unsigned CTRL_W      = 8;
    localparam int unsigned MASK_W      = 8;
    localparam int unsigned SEVEN_POS   = 6;
    localparam int unsigned FEEDBACK_POS = 14;

    localparam logic [LFSR_W-1:0] LFSR_RESET = 15'h7FFF;
    localparam logic [MASK_W-1:0] MASK_ON    = 8'hFF;
    localparam logic [MASK_W-1:0] MASK_OFF   = 8'h00;

    // register index, taken from the word address bit
    localparam logic REG_NOISE_CONTROL = 1'b0;

    // input commands
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic restart;  // reload LFSR, clear phase
        logic add;      // add elapsed cycles to phase
        logic step;     // subtract one period, clock LFSR once
        logic capture;  // load output mask from LFSR
    } t_dp_cmd;

    typedef struct packed {
        logic above;    // phase at or above the period
    } t_dp_status;

    // period = divisor << (shift + 1)
    function automatic logic [PERIOD_W-1:0] period_of(input logic [CTRL_W-1:0] ctrl);
        logic [6:0]          base;
        logic [4:0]          sh;
        logic [PERIOD_W-1:0] ext;
        case (ctrl[2:0])
            3'd0:    base = 7'd8;
            3'd1:    base = 7'd16;
            3'd2:    base = 7'd32;
            3'd3:    base = 7'd48;
            3'd4:    base = 7'd64;
            3'd5:    base = 7'd80;
            3'd6:    base = 7'd96;
            default: base = 7'd112;
        endcase
        sh  = {1'b0, ctrl[7:4]} + 5'd1;
        ext = PERIOD_W'(base);
        return ext << sh;
    endfunction

endpackage

/* rtl/core/lnc_ctrl.sv */
module lnc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lnc_pkg::t_dp_status i_status,
    output lnc_pkg::t_dp_cmd    o_cmd
);
    import lnc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DELIVER
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_take;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_take     = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_cmd == CMD_RESTART) begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_DELIVER;
                    end else begin
                        o_cmd.add = 1'b1;
                        n_state   = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_status.above) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/lnc_datapath.sv */
module lnc_datapath #(
    parameter int unsigned CYCLE_FIELD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [CYCLE_FIELD_BITS-1:0]   i_cycles,
    input  logic [lnc_pkg::CTRL_W-1:0]    i_ctrl,
    input  lnc_pkg::t_dp_cmd              i_cmd,
    output lnc_pkg::t_dp_status           o_status,
    output logic [lnc_pkg::MASK_W-1:0]    o_mask
);
    import lnc_pkg::*;

    // phase holds a leftover below the old period plus one advance
    localparam int unsigned BASE_W  = (CYCLE_FIELD_BITS > PERIOD_W) ? CYCLE_FIELD_BITS
                                                                    : PERIOD_W;
    localparam int unsigned PHASE_W = BASE_W + 1;

    logic [LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [MASK_W-1:0]  r_mask;
    logic [PHASE_W-1:0] period;
    logic [LFSR_W-1:0]  lfsr_stepped;
    logic               fb;

    assign period = PHASE_W'(period_of(i_ctrl));
    assign o_status.above = (r_phase >= period);
    assign o_mask = r_mask;

    always_comb begin
        fb           = r_lfsr[0] ^ r_lfsr[1];
        lfsr_stepped = {fb, r_lfsr[LFSR_W-1:1]};
        if (i_ctrl[3]) begin
            lfsr_stepped[SEVEN_POS] = fb;
        end
    end

    always_comb begin
        n_lfsr  = r_lfsr;
        n_phase = r_phase;
        if (i_cmd.restart) begin
            n_lfsr  = LFSR_RESET;
            n_phase = '0;
        end else if (i_cmd.add) begin
            n_phase = r_phase + PHASE_W'(i_cycles);
        end else if (i_cmd.step) begin
            n_phase = r_phase - period;
            n_lfsr  = lfsr_stepped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr  <= LFSR_RESET;
            r_phase <= '0;
        end else begin
            r_lfsr  <= n_lfsr;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_OFF;
        end else if (i_cmd.capture) begin
            r_mask <= r_lfsr[0] ? MASK_OFF : MASK_ON;
        end
    end

endmodule

/* rtl/core/lfsr_noise_channel.sv */
// Noise channel of a sound chip: a 15-bit LFSR (or 7-bit in seven-bit mode)
// clocked once per elapsed period, period = divisor << (shift + 1).
// Configuration: APB-style port, one register noise_control at byte address 0
// (divisor code bits 2:0, seven-bit mode bit 3, shift bits 7:4). Write it only
// while the channel is idle. pready is tied high.
// Input channel (i_in_valid / o_in_ready): i_cmd advance or restart, i_cycles
// elapsed cycles. Output channel (o_out_valid / i_out_ready): one sample mask
// per input transaction, 0xFF while LFSR bit 0 is clear, else 0x00.
// Sequence: a restart reloads the LFSR and goes straight to delivery; an
// advance adds i_cycles to the phase, then drains one LFSR clock per whole
// period held in the phase and delivers.
// The drain loop does one compare-and-subtract of the period per cycle; a new
// transaction is accepted only once the last result is in the output register.
// A new input transaction is accepted while a finished result still waits in
// the output register; if the receiver stalls, the next result holds in the
// controller until the output register frees up.
// Reset: LFSR to all ones, phase to zero, noise_control to zero (period 16,
// fifteen-bit mode), output register empty.
module lfsr_noise_channel #(
    parameter int unsigned CYCLE_FIELD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [CYCLE_FIELD_BITS-1:0] i_cycles,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_sample_mask,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lnc_pkg::*;

    logic [CTRL_W-1:0] r_noise_control;
    logic              cfg_write;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    // No wait states in the access phase; the word address is paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_control <= '0;
        end else if (cfg_write && (paddr[2] == REG_NOISE_CONTROL)) begin
            r_noise_control <= pwdata[CTRL_W-1:0];
        end
    end

    // Read back the control register; unmapped words read as zero.
    assign prdata = (paddr[2] == REG_NOISE_CONTROL) ? {24'b0, r_noise_control} : 32'b0;

    // Sequence accept, drain and deliver.
    lnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Hold LFSR, phase accumulator and the output mask register.
    lnc_datapath #(
        .CYCLE_FIELD_BITS (CYCLE_FIELD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cycles (i_cycles),
        .i_ctrl   (r_noise_control),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_mask   (o_sample_mask)
    );

endmodule

/* bench/lfsr_noise_channel_tb.sv */
`timescale 1ns / 1ps

module lfsr_noise_channel_tb;

    import lnc_pkg::*;

    localparam int unsigned CYC_W       = 12;
    localparam int unsigned CLK_HALF    = 10;
    localparam int unsigned RST_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS = 135;
    localparam int unsigned RESTART_PCT = 8;
    localparam longint unsigned CYCLE_LIMIT = 2_000_000;

    // The LFSR repeats with a period dividing 32767*127 once it has settled;
    // huge clock counts fold down by that orbit, past the settling clocks.
    localparam longint unsigned LFSR_ORBIT  = 64'd32767 * 64'd127;
    localparam longint unsigned LFSR_SETTLE = 16;

    // Predicts the sample mask of every accepted transaction and checks the
    // results against the oldest prediction still waiting.
    class mask_scoreboard;
        logic [LFSR_W-1:0] lfsr;
        longint unsigned   phase;
        logic [CTRL_W-1:0] control;
        logic [MASK_W-1:0] pending_masks[$];
        int unsigned       mismatches;
        int unsigned       advances;
        int unsigned       restarts;
        longint unsigned   lfsr_clocks;

        function new();
            lfsr    = LFSR_RESET;
            phase   = 0;
            control = '0;
        endfunction

        function longint unsigned noise_period();
            longint unsigned divisor;
            divisor = (control[2:0] == 3'd0) ? 64'd8 : 64'd16 * control[2:0];
            return divisor << (control[7:4] + 1);
        endfunction

        function void clock_lfsr();
            logic fb;
            fb   = lfsr[0] ^ lfsr[1];
            lfsr = {fb, lfsr[LFSR_W-1:1]};
            if (control[3])
                lfsr[SEVEN_POS] = fb;
        endfunction

        function void note_transaction(input logic cmd, input logic [CYC_W-1:0] cycles);
            longint unsigned   period;
            longint unsigned   clocks;
            logic [MASK_W-1:0] mask;
            if (cmd == CMD_RESTART) begin
                lfsr  = LFSR_RESET;
                phase = 0;
                mask  = MASK_OFF;
                restarts++;
            end else begin
                period = noise_period();
                phase  = phase + cycles;
                clocks = phase / period;
                phase  = phase % period;
                lfsr_clocks += clocks;
                if (clocks >= LFSR_ORBIT + LFSR_SETTLE)
                    clocks = LFSR_SETTLE + (clocks - LFSR_SETTLE) % LFSR_ORBIT;
                while (clocks > 0) begin
                    clock_lfsr();
                    clocks--;
                end
                mask = lfsr[0] ? MASK_OFF : MASK_ON;
                advances++;
            end
            pending_masks.push_back(mask);
        endfunction

        function void check_mask(input logic [MASK_W-1:0] actual);
            logic [MASK_W-1:0] expected;
            if (pending_masks.size() == 0) begin
                $error("sample_mask: expected nothing, got %02h", actual);
                mismatches++;
            end else begin
                expected = pending_masks.pop_front();
                if (actual !== expected) begin
                    $error("sample_mask: expected %02h, got %02h", expected, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             i_cmd = CMD_ADVANCE;
    logic [CYC_W-1:0] i_cycles = '0;
    logic             i_out_ready = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [7:0]       o_sample_mask;
    logic [31:0]      prdata;
    logic             pready;

    mask_scoreboard   sb = new();
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      settings_written = 0;
    longint unsigned  cycle_count = 0;

    lfsr_noise_channel #(
        .CYCLE_FIELD_BITS(CYC_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_cycles      (i_cycles),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample_mask (o_sample_mask),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Stop a hung run. The slowest legal run (full drains, heavy stalls)
    // stays well under this limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_masks.size());
            $display("lfsr_noise_channel regression: fail");
            $finish;
        end
    end

    // Stall the receiver at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both channels at the edge. All signals here still hold their
    // pre-edge values, so acceptance is decided exactly as the block sees it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_mask(o_sample_mask);
            if (i_in_valid && o_in_ready)
                sb.note_transaction(i_cmd, i_cycles);
        end
    end

    // Offer one transaction, idling the sender first at the phase's rate.
    // Return in the step of acceptance; valid stays high so the caller either
    // offers the next transaction or lowers valid in that same step.
    task automatic send_item(input logic cmd, input logic [CYC_W-1:0] cyc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_cmd      <= 1'($urandom);
            i_cycles   <= CYC_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_cycles   <= cyc;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, then hold until every predicted mask has come back, and then let
    // the block idle for a spare tail. Step past the current edge first so the last
    // accepted transaction is already noted.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_masks.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // APB write of noise_control: setup cycle, then access until pready.
    task automatic write_control(input logic [CTRL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NOISE_CONTROL, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.control = value;
        settings_written++;
    endtask

    initial begin
        logic [CTRL_W-1:0] ctrl;
        logic              cmd;
        logic [CYC_W-1:0]  cyc;
        int unsigned       pick;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset setting first: period 16, fifteen-bit mode.
        send_item(CMD_ADVANCE, 12'd0);       // no clock, mask from all-ones LFSR
        send_item(CMD_ADVANCE, 12'd15);      // one short of a period
        send_item(CMD_ADVANCE, 12'd1);       // reaches the period exactly
        send_item(CMD_ADVANCE, 12'd4095);    // widest advance
        send_item(CMD_RESTART, 12'd4095);    // restart ignores the cycle count
        send_item(CMD_ADVANCE, 12'd16);
        send_item(CMD_RESTART, 12'd0);
        send_item(CMD_ADVANCE, 12'd32);
        settle_idle();

        // Seven-bit mode at the shortest period.
        write_control(8'h08);
        send_item(CMD_ADVANCE, 12'd4095);
        send_item(CMD_ADVANCE, 12'd37);
        send_item(CMD_ADVANCE, 12'd0);
        settle_idle();

        // Longest period: build up phase without clocking the LFSR.
        write_control(8'hFF);
        send_item(CMD_ADVANCE, 12'd4095);
        send_item(CMD_ADVANCE, 12'd4095);
        send_item(CMD_ADVANCE, 12'd4095);
        settle_idle();

        // Shrink the period under the kept phase: the next advance drains it,
        // even with zero elapsed cycles.
        write_control(8'h00);
        send_item(CMD_ADVANCE, 12'd0);
        send_item(CMD_ADVANCE, 12'd2048);
        settle_idle();

        write_control(8'hF7);
        send_item(CMD_ADVANCE, 12'd4095);
        send_item(CMD_RESTART, 12'h555);
        send_item(CMD_ADVANCE, 12'hAAA);
        settle_idle();

        // Random phases: each with a fresh setting and one of four idling
        // patterns. Shifts stay small most of the time so the LFSR moves.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            if ($urandom_range(9) < 7)
                ctrl = {4'($urandom_range(2)), 1'($urandom), 3'($urandom)};
            else
                ctrl = CTRL_W'($urandom);
            write_control(ctrl);

            repeat (PHASE_ITEMS) begin
                cmd  = ($urandom_range(99) < RESTART_PCT) ? CMD_RESTART : CMD_ADVANCE;
                pick = $urandom_range(9);
                if (pick < 4)
                    cyc = CYC_W'($urandom_range(63));
                else if (pick < 8)
                    cyc = CYC_W'($urandom);
                else if (pick == 8)
                    cyc = '0;
                else
                    cyc = '1;
                send_item(cmd, cyc);
            end
            settle_idle();
        end

        $display("covered %0d advances and %0d restarts over %0d control settings",
                 sb.advances, sb.restarts, settings_written);
        $display("LFSR clocked %0d times in %0d cycles, four idling patterns",
                 sb.lfsr_clocks, cycle_count);
        if (sb.mismatches == 0 && sb.pending_masks.size() == 0) begin
            $display("lfsr_noise_channel regression: pass");
        end else begin
            $display("lfsr_noise_channel regression: fail");
        end
        $finish;
    end

endmodule
